### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes; code 3 is undefined and treated as a no-op
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One queue entry
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;    // insert the new entry in sorted position
        logic   rem;    // remove the head, everything moves one slot toward it
        t_entry ent;    // entry being inserted
    } t_cell_cmd;

endpackage

### rtl/spq_intf.sv
// ----------------------------------------------------------------------------
// spq_intf
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::ACTION_W-1:0] action;
    logic signed [spq_pkg::VALUE_W-1:0] item_value;
    logic [spq_pkg::PRIO_W-1:0]   item_priority;

    modport source (output valid, action, item_value, item_priority, input ready);
    modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic signed [spq_pkg::VALUE_W-1:0] head_value;
    logic                         value_valid;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, head_value, value_valid, status, occupancy, input ready);
    modport sink   (input valid, head_value, value_valid, status, occupancy, output ready);
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Compares its priority with the incoming
// entry and takes either its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occ,        // slot holds a live entry
    input  logic               i_left_keep,  // left neighbor keeps its entry
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Ties stay ahead of the new entry, so equal priorities keep arrival order
    assign o_keep = i_occ && (r_entry.prio <= i_cmd.ent.prio);

    // Next entry: stay, take the new word, or shift from a neighbor
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_cmd.ent : i_left_entry;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries request words (action, item_value, item_priority); o_out
//   carries one result word per request (head_value, value_valid, status,
//   occupancy). Both channels use valid/ready.
//   Every cell compares its priority with the incoming one in the same cycle,
//   so an insert, remove or peek ends as it is taken: one request word is
//   taken per cycle while i_in.ready is high, its result on o_out the next cycle.
//   The result sits in an output register; a new request is taken while
//   that register is empty or being drained in the same cycle.
//   Enqueue into a full queue returns status full and drops the entry;
//   dequeue or peek on an empty queue returns status empty.
//   Reset clears the entry count and the output valid; the slot contents
//   are not cleared, as only occupied slots are ever read.
//   When the receiver stalls, the result holds and i_in.ready drops.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_req_if.sink      i_in,
    spq_rsp_if.source    o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovalid;

    // Result payload
    logic signed [spq_pkg::VALUE_W-1:0] r_head;
    logic                               r_hvalid;
    spq_pkg::t_status                   r_status;

    logic                               accept;
    logic                               full;
    logic                               empty;
    spq_pkg::t_action                   act;
    spq_pkg::t_cell_cmd                 cmd;
    logic signed [spq_pkg::VALUE_W-1:0] n_head;
    logic                               n_hvalid;
    spq_pkg::t_status                   n_status;
    logic [CNT_W+spq_pkg::OCC_W-1:0]    occ_ext;

    spq_pkg::t_entry cell_entry [DEPTH];
    logic            cell_keep  [DEPTH];

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign act        = spq_pkg::t_action'(i_in.action);

    // Request decode
    always_comb begin
        cmd.ins      = 1'b0;
        cmd.rem      = 1'b0;
        cmd.ent.value = i_in.item_value;
        cmd.ent.prio  = i_in.item_priority;
        n_count      = r_count;
        n_head       = '0;
        n_hvalid     = 1'b0;
        n_status     = spq_pkg::ST_OK;
        unique case (act)
            spq_pkg::ACT_ENQ: begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    cmd.ins = accept;
                    n_count = r_count + 1'b1;
                end
            end
            spq_pkg::ACT_DEQ: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    cmd.rem  = accept;
                    n_count  = r_count - 1'b1;
                    n_head   = cell_entry[0].value;
                    n_hvalid = 1'b1;
                end
            end
            spq_pkg::ACT_PEEK: begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_head   = cell_entry[0].value;
                    n_hvalid = 1'b1;
                end
            end
            default: begin
                // undefined code: no change, plain ok result
            end
        endcase
    end

    // Chain of cells, slot 0 is the head
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic            left_keep;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        if (gi == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = cmd.ent;
        end else begin : g_body
            assign left_keep  = cell_keep[gi-1];
            assign left_entry = cell_entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[gi];
        end else begin : g_inner
            assign right_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occ         (CNT_W'(gi) < r_count),
            .i_left_keep   (left_keep),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[gi]),
            .o_keep        (cell_keep[gi])
        );
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_in.ready) begin
                r_ovalid <= i_in.valid;
            end
        end
    end

    // Result payload, occupancy is taken from r_count
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head   <= n_head;
            r_hvalid <= n_hvalid;
            r_status <= n_status;
        end
    end

    // Occupancy reported modulo 2^OCC_W
    assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, r_count};

    assign o_out.valid       = r_ovalid;
    assign o_out.head_value  = r_head;
    assign o_out.value_valid = r_hvalid;
    assign o_out.status      = r_status;
    assign o_out.occupancy   = occ_ext[spq_pkg::OCC_W-1:0];

endmodule

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int DEPTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_value_valid,
    input logic [spq_pkg::STATUS_W-1:0] i_status,
    input logic [spq_pkg::OCC_W-1:0]    i_occupancy
);

    // A real head word only comes with an ok status
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_value_valid |-> i_status == spq_pkg::ST_OK)
        else $error("head word flagged with non-ok status");

    // Empty status means nothing is held
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == spq_pkg::ST_EMPTY |-> i_occupancy == '0)
        else $error("empty status with nonzero occupancy");

    // Full status means the queue is at capacity
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == spq_pkg::ST_FULL
            |-> i_occupancy == spq_pkg::OCC_W'(DEPTH))
        else $error("full status below capacity");

    // No stall while the result register is free or draining
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("request stalled with free result register");

    // No result word in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result word right after reset");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_value_valid (o_out.value_valid),
    .i_status      (o_out.status),
    .i_occupancy   (o_out.occupancy)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue: drives request words
// with random gaps, stalls the result channel at random, and compares every
// result word with a behavioral copy of the queue kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int QUEUE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 250;

    // Action code 3 is undefined; the block reports and ignores it
    localparam logic [spq_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;

    // One result word as the block reports it
    typedef struct packed {
        logic signed [spq_pkg::VALUE_W-1:0] head_value;
        logic                               value_valid;
        spq_pkg::t_status                   status;
        logic [spq_pkg::OCC_W-1:0]          occupancy;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Shadow copy of the queue, slot 0 is the head
    logic signed [spq_pkg::VALUE_W-1:0] shadow_values [QUEUE_DEPTH];
    logic [spq_pkg::PRIO_W-1:0]         shadow_prios  [QUEUE_DEPTH];
    int                                 shadow_count;

    t_result pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int results_checked;
    int full_hits;
    int empty_hits;
    int error_count;

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: random stalls on the result channel
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Apply one request to the shadow queue and return the word it should give
    function automatic t_result apply_queue_op(
            input logic [spq_pkg::ACTION_W-1:0]        act,
            input logic signed [spq_pkg::VALUE_W-1:0]  val,
            input logic [spq_pkg::PRIO_W-1:0]          pri);
        t_result res;
        int      pos;
        int      k;
        res = '0;
        res.status = spq_pkg::ST_OK;
        case (act)
            spq_pkg::ACT_ENQ: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    res.status = spq_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    // land behind every entry of equal or smaller priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prios[pos] <= pri)
                        pos++;
                    for (k = shadow_count; k > pos; k--) begin
                        shadow_values[k] = shadow_values[k-1];
                        shadow_prios[k]  = shadow_prios[k-1];
                    end
                    shadow_values[pos] = val;
                    shadow_prios[pos]  = pri;
                    shadow_count++;
                end
            end
            spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK: begin
                if (shadow_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                    empty_hits++;
                end else begin
                    res.head_value  = shadow_values[0];
                    res.value_valid = 1'b1;
                    if (act == spq_pkg::ACT_DEQ) begin
                        for (k = 1; k < shadow_count; k++) begin
                            shadow_values[k-1] = shadow_values[k];
                            shadow_prios[k-1]  = shadow_prios[k];
                        end
                        shadow_count--;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = shadow_count[spq_pkg::OCC_W-1:0];
        return res;
    endfunction

    // Monitor: check the result word first, then log the accepted request
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result word: expected none, got value %0d status %0d",
                         $time, rsp_if.head_value, rsp_if.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.head_value !== want.head_value) begin
                    $display("%0t head_value: expected %0d, got %0d",
                             $time, want.head_value, rsp_if.head_value);
                    error_count++;
                end
                if (rsp_if.value_valid !== want.value_valid) begin
                    $display("%0t value_valid: expected %0b, got %0b",
                             $time, want.value_valid, rsp_if.value_valid);
                    error_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t status: expected %0d, got %0d",
                             $time, want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.occupancy !== want.occupancy) begin
                    $display("%0t occupancy: expected %0d, got %0d",
                             $time, want.occupancy, rsp_if.occupancy);
                    error_count++;
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            words_sent++;
            pending_results.push_back(apply_queue_op(req_if.action, req_if.item_value,
                                                     req_if.item_priority));
        end
    end

    // Send one request word, with random idle cycles ahead of it
    task automatic send_word(input logic [spq_pkg::ACTION_W-1:0]       act,
                             input logic signed [spq_pkg::VALUE_W-1:0] val,
                             input logic [spq_pkg::PRIO_W-1:0]         pri);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid         <= 1'b0;
            req_if.action        <= spq_pkg::ACTION_W'($urandom_range(0, 3));
            req_if.item_value    <= $urandom;
            req_if.item_priority <= spq_pkg::PRIO_W'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.item_value    <= val;
        req_if.item_priority <= pri;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Peek, dequeue and the undefined code against an empty queue
    task automatic test_empty_access();
        send_word(spq_pkg::ACT_PEEK, 32'sd5, 8'd1);
        send_word(spq_pkg::ACT_DEQ, -32'sd5, 8'd2);
        send_word(ACT_NOP, 32'sd9, 8'd3);
    endtask

    // Fill with extremes and ties, then push past full
    task automatic test_fill_and_overflow();
        int k;
        send_word(spq_pkg::ACT_ENQ, 32'sh8000_0000, 8'd255);
        send_word(spq_pkg::ACT_ENQ, 32'sh7fff_ffff, 8'd0);
        send_word(spq_pkg::ACT_ENQ, 32'sd0, 8'd0);          // ties with head, goes behind it
        for (k = 0; k < QUEUE_DEPTH - 3; k++)
            send_word(spq_pkg::ACT_ENQ, $urandom, spq_pkg::PRIO_W'((k % 4) * 60));
        send_word(spq_pkg::ACT_ENQ, -32'sd1, 8'd0);         // dropped, queue full
        send_word(ACT_NOP, 32'sd1, 8'd0);
    endtask

    // Peek then remove the head a couple of times
    task automatic test_head_access();
        send_word(spq_pkg::ACT_PEEK, 32'sd0, 8'd0);
        send_word(spq_pkg::ACT_DEQ, 32'sd0, 8'd0);
        send_word(spq_pkg::ACT_DEQ, 32'sd0, 8'd0);
    endtask

    // Random traffic swinging between filling and draining the queue
    task automatic test_random_mix(input int n_words);
        int                                 n;
        int                                 roll;
        bit                                 filling;
        logic [spq_pkg::ACTION_W-1:0]       act;
        logic signed [spq_pkg::VALUE_W-1:0] val;
        logic [spq_pkg::PRIO_W-1:0]         pri;
        filling = 1'b1;
        for (n = 0; n < n_words; n++) begin
            if (shadow_count >= QUEUE_DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (shadow_count == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                act = ACT_NOP;
            else if (roll < (filling ? 70 : 30))
                act = spq_pkg::ACT_ENQ;
            else if ($urandom_range(0, 9) < 7)
                act = spq_pkg::ACT_DEQ;
            else
                act = spq_pkg::ACT_PEEK;
            // narrow priorities make ties common
            roll = $urandom_range(0, 9);
            if (roll < 5)
                pri = spq_pkg::PRIO_W'($urandom_range(0, 3));
            else if (roll < 9)
                pri = spq_pkg::PRIO_W'($urandom_range(0, 255));
            else
                pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            val = $urandom;
            send_word(act, val, pri);
        end
    endtask

    // Main sequence
    initial begin
        req_if.valid         = 1'b0;
        req_if.action        = spq_pkg::ACT_ENQ;
        req_if.item_value    = '0;
        req_if.item_priority = '0;
        shadow_count         = 0;
        words_sent           = 0;
        results_checked      = 0;
        full_hits            = 0;
        empty_hits           = 0;
        error_count          = 0;
        send_idle_pct        = 21;
        recv_stall_pct       = 52;
        i_rst_n              = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_access();
        test_fill_and_overflow();
        test_head_access();
        test_random_mix(RANDOM_WORDS);

        send_idle_pct  = 52;
        recv_stall_pct = 21;
        test_random_mix(RANDOM_WORDS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(RANDOM_WORDS);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d request words through the queue, %0d result words checked.",
                 words_sent, results_checked);
        $display("Overflow drops seen: %0d, empty accesses seen: %0d.",
                 full_hits, empty_hits);
        if (error_count == 0) begin
            $display("sorted_priority_queue_unit: match");
        end else begin
            $display("sorted_priority_queue_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d result words outstanding.", pending_results.size());
        $display("sorted_priority_queue_unit: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_intf.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_checker.sv
sim/testbench.sv
